[design/tdf_pkg.sv]
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared types and constants for the text display filter: register map,
// character codes, the BCD line-number type and the front/back queue word.
// ----------------------------------------------------------------------------
package tdf_pkg;

   localparam int NUMBER_DIGITS = 6;
   localparam int POS_W         = $clog2(NUMBER_DIGITS + 1);
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W        = 5;
   localparam int DATA_W        = 32;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_SQUEEZE_BLANK    = 3'd0;
   localparam logic [2:0] REG_NUMBER_NONBLANK  = 3'd1;
   localparam logic [2:0] REG_NUMBER_ALL       = 3'd2;
   localparam logic [2:0] REG_SHOW_ENDS        = 3'd3;
   localparam logic [2:0] REG_SHOW_TABS        = 3'd4;
   localparam logic [2:0] REG_SHOW_NONPRINTING = 3'd5;

   // character codes
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_I      = 8'h49;
   localparam logic [7:0] CH_M      = 8'h4D;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam logic [7:0] CTRL_OFS  = 8'h40;
   localparam logic [7:0] CTRL_END  = 8'h20;
   localparam logic [3:0] ZONE_DIG  = 4'h3;
   localparam logic [3:0] BCD_NINE  = 4'd9;

   // index 0 is the least significant digit
   typedef logic [NUMBER_DIGITS-1:0][3:0] number_type;

   typedef struct packed {
      logic squeeze_blank;
      logic number_nonblank;
      logic number_all;
      logic show_ends;
      logic show_tabs;
      logic show_nonprinting;
   } cfg_type;

   // one queued item: optional line number, then 1..4 rendered bytes
   typedef struct packed {
      logic            numbered;
      number_type      number;
      logic [1:0]      last_idx;
      logic [3:0][7:0] glyph;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

[design/tdf_front.sv]
// ----------------------------------------------------------------------------
// tdf_front
// Accepts text bytes, tracks blank-line squeezing and line numbering, and
// renders each byte into a queue word for the back end.
// ----------------------------------------------------------------------------
module tdf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  tdf_pkg::cfg_type      cfg,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_text_byte,
   input  tdf_pkg::q_stat_type   q_stat,
   output logic                  push,
   output tdf_pkg::entry_type    push_entry
);
   import tdf_pkg::*;

   logic [1:0] run_ff, run_in, run_inc;
   logic       start_ff, start_in;
   number_type num_ff, num_in;
   logic       nb_start_ff, nb_start_in;
   logic       any_start_ff, any_start_in;
   logic       accept, is_nl, drop, numbered;
   logic [7:0] c, lo;

   // saturating BCD increment; holds at all nines
   function automatic number_type bcd_inc(input number_type v);
      number_type r;
      logic       carry;
      logic       all9;
      r     = v;
      carry = 1'b1;
      all9  = 1'b1;
      for (int k = 0; k < NUMBER_DIGITS; k++) begin
         all9 = all9 & (v[k] == BCD_NINE);
         if (carry) begin
            if (v[k] == BCD_NINE) begin
               r[k] = 4'd0;
            end else begin
               r[k]  = v[k] + 4'd1;
               carry = 1'b0;
            end
         end
      end
      if (all9) begin
         r = v;
      end
      return r;
   endfunction

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !q_stat.full;
   assign c         = req_text_byte;
   assign lo        = {1'b0, c[6:0]};
   assign is_nl     = (c == CH_NL);
   assign run_inc   = (run_ff == 2'd3) ? 2'd3 : run_ff + 2'd1;

   always_comb begin
      run_in       = run_ff;
      start_in     = start_ff;
      nb_start_in  = nb_start_ff;
      any_start_in = any_start_ff;
      drop         = 1'b0;
      numbered     = 1'b0;

      if (cfg.squeeze_blank && is_nl) begin
         run_in = run_inc;
         if (run_inc == 2'd3) begin
            drop = 1'b1;
         end
         if (start_ff && run_inc > 2'd1) begin
            drop = 1'b1;
         end
      end else begin
         start_in = 1'b0;
         run_in   = 2'd0;
      end

      // a squeezed newline leaves the line-start flags alone
      if (!drop) begin
         if (cfg.number_nonblank) begin
            if (!is_nl) begin
               if (nb_start_ff) begin
                  numbered    = 1'b1;
                  nb_start_in = 1'b0;
               end
            end else begin
               nb_start_in = 1'b1;
            end
         end else if (cfg.number_all) begin
            numbered     = any_start_ff;
            any_start_in = is_nl;
         end
      end

      num_in = numbered ? bcd_inc(num_ff) : num_ff;
   end

   // rendering of the byte itself
   always_comb begin
      push_entry.numbered = numbered;
      push_entry.number   = num_ff;
      push_entry.glyph    = '0;
      push_entry.glyph[0] = c;
      push_entry.last_idx = 2'd0;
      if (cfg.show_tabs && c == CH_TAB) begin
         push_entry.glyph[0] = CH_CARET;
         push_entry.glyph[1] = CH_I;
         push_entry.last_idx = 2'd1;
      end else if (cfg.show_ends && is_nl) begin
         push_entry.glyph[0] = CH_DOLLAR;
         push_entry.glyph[1] = CH_NL;
         push_entry.last_idx = 2'd1;
      end else if (cfg.show_nonprinting && c < CTRL_END && c != CH_TAB && !is_nl) begin
         push_entry.glyph[0] = CH_CARET;
         push_entry.glyph[1] = c + CTRL_OFS;
         push_entry.last_idx = 2'd1;
      end else if (cfg.show_nonprinting && c[7]) begin
         push_entry.glyph[0] = CH_M;
         push_entry.glyph[1] = CH_DASH;
         if (lo < CTRL_END) begin
            push_entry.glyph[2] = CH_CARET;
            push_entry.glyph[3] = lo + CTRL_OFS;
            push_entry.last_idx = 2'd3;
         end else if (lo == CH_DEL) begin
            push_entry.glyph[2] = CH_CARET;
            push_entry.glyph[3] = CH_QMARK;
            push_entry.last_idx = 2'd3;
         end else begin
            push_entry.glyph[2] = lo;
            push_entry.last_idx = 2'd2;
         end
      end else if (cfg.show_nonprinting && c == CH_DEL) begin
         push_entry.glyph[0] = CH_CARET;
         push_entry.glyph[1] = CH_QMARK;
         push_entry.last_idx = 2'd1;
      end
   end

   assign push = accept && !drop;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 2'd0;
         start_ff     <= 1'b1;
         num_ff       <= number_type'(1);
         nb_start_ff  <= 1'b1;
         any_start_ff <= 1'b1;
      end else if (accept) begin
         run_ff       <= run_in;
         start_ff     <= start_in;
         num_ff       <= num_in;
         nb_start_ff  <= nb_start_in;
         any_start_ff <= any_start_in;
      end
   end

endmodule

[design/tdf_queue.sv]
// ----------------------------------------------------------------------------
// tdf_queue
// Small register FIFO that decouples the classifying front from the
// byte-emitting back end.
// ----------------------------------------------------------------------------
module tdf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tdf_pkg::entry_type    push_entry,
   input  logic                  pop,
   output tdf_pkg::entry_type    head,
   output tdf_pkg::q_stat_type   q_stat
);
   import tdf_pkg::*;

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign head         = slot_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

[design/tdf_back.sv]
// ----------------------------------------------------------------------------
// tdf_back
// Walks the head queue word one byte per cycle while rsp_stall is low: line-number digits
// and tab first when numbered, then the rendered bytes, into the output register.
// ----------------------------------------------------------------------------
module tdf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  tdf_pkg::q_stat_type   q_stat,
   input  tdf_pkg::entry_type    head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_display_byte,
   output logic                  rsp_run_last
);
   import tdf_pkg::*;

   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             num_done_ff, num_done_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [1:0]       idx_ff, idx_in;
   logic             load, pos_end, blank, nz;
   logic [3:0]       digit;

   assign load    = (!valid_ff || !rsp_stall) && !q_stat.empty;
   assign pos_end = (pos_ff == POS_W'(NUMBER_DIGITS));

   // digit under the cursor; leading zeros show as spaces, units digit never
   always_comb begin
      digit = 4'd0;
      blank = 1'b0;
      nz    = 1'b0;
      for (int k = NUMBER_DIGITS - 1; k >= 0; k--) begin
         nz = nz | (head.number[k] != 4'd0);
         if (pos_ff == POS_W'(NUMBER_DIGITS - 1 - k)) begin
            digit = head.number[k];
            blank = (k != 0) && !nz;
         end
      end
   end

   always_comb begin
      num_done_in = num_done_ff;
      pos_in      = pos_ff;
      idx_in      = idx_ff;
      pop         = 1'b0;
      if (head.numbered && !num_done_ff) begin
         byte_in     = pos_end ? CH_TAB : (blank ? CH_SPACE : {ZONE_DIG, digit});
         last_in     = 1'b0;
         num_done_in = pos_end;
         pos_in      = pos_end ? '0 : pos_ff + 1'b1;
      end else begin
         byte_in = head.glyph[idx_ff];
         last_in = (idx_ff == head.last_idx);
         pop     = load && last_in;
         idx_in  = last_in ? 2'd0 : idx_ff + 2'd1;
         if (last_in) begin
            num_done_in = 1'b0;
         end
      end

      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         num_done_ff <= 1'b0;
         pos_ff      <= '0;
         idx_ff      <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            num_done_ff <= num_done_in;
            pos_ff      <= pos_in;
            idx_ff      <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_display_byte = byte_ff;
   assign rsp_run_last     = last_ff;

endmodule

[design/text_display_filter_top.sv]
// ----------------------------------------------------------------------------
// text_display_filter_top
// Byte-stream text display filter: blank-line squeezing, line numbering,
// tab/end marks and caret / M- rendering of nonprinting bytes.
// ----------------------------------------------------------------------------
// One text byte is taken per cycle while the 4-word internal queue has room;
// each byte leaves as 0 to NUMBER_DIGITS+5 display words, one word per cycle
// from the output register while rsp_stall is low, the last one flagged with
// rsp_run_last. The output side sets the rate: a byte yields one word for plain
// text, seven more when a line number is printed, none for a squeezed newline.
// Input stall rises only when the queue is full. Registers must be written over
// the csr_ port only while the stream is idle; the block does not enforce this.
module text_display_filter_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_text_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_display_byte,
   output logic                       rsp_run_last,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [tdf_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [tdf_pkg::DATA_W-1:0] csr_pwdata,
   output logic [tdf_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);
   import tdf_pkg::*;

   cfg_type    cfg_ff;
   logic       cfg_wr;
   logic [2:0] reg_idx;
   logic       rd_bit;
   logic       q_push, q_pop;
   entry_type  push_entry, head;
   q_stat_type q_stat;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (cfg_wr) begin
         case (reg_idx)
            REG_SQUEEZE_BLANK:    cfg_ff.squeeze_blank    <= csr_pwdata[0];
            REG_NUMBER_NONBLANK:  cfg_ff.number_nonblank  <= csr_pwdata[0];
            REG_NUMBER_ALL:       cfg_ff.number_all       <= csr_pwdata[0];
            REG_SHOW_ENDS:        cfg_ff.show_ends        <= csr_pwdata[0];
            REG_SHOW_TABS:        cfg_ff.show_tabs        <= csr_pwdata[0];
            REG_SHOW_NONPRINTING: cfg_ff.show_nonprinting <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SQUEEZE_BLANK:    rd_bit = cfg_ff.squeeze_blank;
         REG_NUMBER_NONBLANK:  rd_bit = cfg_ff.number_nonblank;
         REG_NUMBER_ALL:       rd_bit = cfg_ff.number_all;
         REG_SHOW_ENDS:        rd_bit = cfg_ff.show_ends;
         REG_SHOW_TABS:        rd_bit = cfg_ff.show_tabs;
         REG_SHOW_NONPRINTING: rd_bit = cfg_ff.show_nonprinting;
         default:              rd_bit = 1'b0;
      endcase
   end

   assign csr_prdata = {{(DATA_W-1){1'b0}}, rd_bit};

   tdf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_byte (req_text_byte),
      .q_stat        (q_stat),
      .push          (q_push),
      .push_entry    (push_entry)
   );

   tdf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   tdf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_stat           (q_stat),
      .head             (head),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_display_byte (rsp_display_byte),
      .rsp_run_last     (rsp_run_last)
   );

   // queue never written while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_stat.full))
      else $error("queue push while full");

   // back end never retires a word that is not there
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_stat.empty))
      else $error("queue pop while empty");

   // output cannot become valid with nothing queued
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && q_stat.empty) |=> !rsp_valid)
      else $error("output word without queued item");

endmodule
